/* hw/rtl/mspf_pkg.sv */
// Shared constants and types for the motor speed PI controller with feedforward.
// No dependencies; imported by every module of the block.
package mspf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_W     = 28;
	localparam int MUL_W     = 44;
	localparam int SUM_W     = 46;

	localparam logic [DIV_W-1:0] RPM_NUMER = DIV_W'(60000000);
	localparam logic [15:0] EMA_DIVISOR = 16'd5;
	localparam logic [10:0] THR_MAX = 11'd1999;
	localparam logic [10:0] THR_MIN_SPIN = 11'd100;
	localparam logic signed [SUM_W-1:0] OUT_HI = SUM_W'(THR_MAX) <<< FRAC_BITS;
	localparam logic signed [SUM_W-1:0] OUT_LO = SUM_W'(THR_MIN_SPIN) <<< FRAC_BITS;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_TARGET = 2'd1;
	localparam logic [1:0] REQ_STOP   = 2'd2;

	localparam logic [2:0] REG_POLES    = 3'd0;
	localparam logic [2:0] REG_MAX_RPM  = 3'd1;
	localparam logic [2:0] REG_KP       = 3'd2;
	localparam logic [2:0] REG_KI       = 3'd3;
	localparam logic [2:0] REG_FF       = 3'd4;
	localparam logic [2:0] REG_MIN_RPM  = 3'd5;
	localparam logic [2:0] REG_STARTUP  = 3'd6;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_DIV1 = 12'b0000_0000_0010,
		ST_DIV2 = 12'b0000_0000_0100,
		ST_EMA  = 12'b0000_0000_1000,
		ST_DIV3 = 12'b0000_0001_0000,
		ST_CHK  = 12'b0000_0010_0000,
		ST_MFF  = 12'b0000_0100_0000,
		ST_MP   = 12'b0000_1000_0000,
		ST_SUM  = 12'b0001_0000_0000,
		ST_MI   = 12'b0010_0000_0000,
		ST_FIN  = 12'b0100_0000_0000,
		ST_OUT  = 12'b1000_0000_0000
	} state_t;

endpackage

/* hw/rtl/mspf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mspf_pkg.
module mspf_div
	import mspf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [15:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [15:0]      rem_q;
	logic [15:0]      dvs_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [16:0]      shifted;
	logic [16:0]      trial;
	logic             fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[15:0] : shifted[15:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/mspf_mul.sv */
// Shift-add multiplier: unsigned 16-bit gain times signed 27-bit value, one gain bit per cycle.
// Depends on mspf_pkg.
module mspf_mul
	import mspf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [15:0]             gain,
	input  logic signed [26:0]      value,
	output logic                    done,
	output logic signed [MUL_W-1:0] product
);

	logic [27:0] hi_q;
	logic [15:0] lo_q;
	logic [26:0] mag_q;
	logic        neg_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [27:0] acc;
	logic [MUL_W-1:0] prod_u;

	assign acc    = hi_q + (lo_q[0] ? {1'b0, mag_q} : 28'd0);
	assign prod_u = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q  <= '0;
			lo_q  <= gain;
			mag_q <= value[26] ? 27'(-value) : 27'(value);
			neg_q <= value[26];
		end else if (busy_q) begin
			hi_q <= {1'b0, acc[27:1]};
			lo_q <= {acc[0], lo_q[15:1]};
		end
	end

	assign done    = done_q;
	assign product = neg_q ? -$signed(prod_u) : $signed(prod_u);

endmodule

/* hw/rtl/motor_speed_pi_feedforward.sv */
// Motor speed controller: period to RPM, EMA smoothing, feedforward plus PI throttle.
// Depends on mspf_pkg, mspf_div and mspf_mul.
//
// Input stream (s_*): s_tuser carries the request kind (tick, set target, stop),
// s_tdata carries target_rpm and the tick period. Set-target and stop requests are
// absorbed on acceptance and give no output. Unused request codes are dropped.
// Each tick gives one output transaction on m_*: throttle, measured speed and
// held target in m_tdata, the motor stop flag in m_tuser.
// A tick runs through a sequencer that shares one bit-serial divider (up to
// three divisions) and one bit-serial multiplier (up to three products); a tick
// with zero period and a target at or below the minimum uses neither unit, while
// the full path with integration uses both. s_tready is high only while the
// sequencer is idle, so the next item is taken the cycle after the result lands.
// The result sits in an output register; the next tick may be taken and worked
// on while it waits, and a finished tick holds until that register is free.
// Configuration writes (cfg_wen, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, which the block does not enforce.
// Reset (arst_n low) restores the default gains and limits and clears the target,
// integrator, smoothed speed and any pending output.
module motor_speed_pi_feedforward
	import mspf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [16:0] target_rpm, [32:17] tick period, zero fill
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [10:0] throttle, [36:11] measured_rpm, [52:37] target_speed
	output logic        m_tuser,  // [0] motor_stop
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  poles_q;
	logic [15:0] max_rpm_q, kp_q, ki_q, ff_q, min_rpm_q;
	logic [10:0] startup_q;

	logic [15:0] held_q;
	logic [26:0] integ_q;
	logic [25:0] smooth_q;

	state_t state_q;
	logic [25:0] mech_q;
	logic        ema_neg_q;
	logic signed [26:0] err_q;
	logic signed [SUM_W-1:0] ffp_q;
	logic signed [SUM_W-1:0] pp_q;
	logic signed [SUM_W-1:0] sum_q;
	logic        stop_q;
	logic [10:0] thr_q;
	logic        integ_done_q;

	logic             div_start_q;
	logic [DIV_W-1:0] div_a_q;
	logic [15:0]      div_b_q;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	logic                    mul_start_q;
	logic [15:0]             mul_g_q;
	logic signed [26:0]      mul_v_q;
	logic                    mul_done;
	logic signed [MUL_W-1:0] mul_prod;

	logic        out_valid_q;
	logic [55:0] out_data_q;
	logic        out_user_q;

	logic        accept;
	logic signed [16:0] in_target;
	logic [15:0] in_period;
	logic [6:0]  pairs;
	logic signed [26:0] ema_diff;
	logic [26:0] ema_abs;
	logic signed [SUM_W-1:0] integ_s;
	logic signed [SUM_W-1:0] sum_now;
	logic signed [SUM_W-1:0] integ_new;
	logic signed [SUM_W-1:0] kick;
	logic signed [SUM_W-1:0] fin_a;
	logic signed [SUM_W-1:0] fin_b;
	logic        out_free;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_target = $signed(s_tdata[16:0]);
	assign in_period = s_tdata[32:17];
	assign pairs     = (poles_q[7:1] == 7'd0) ? 7'd1 : poles_q[7:1];
	assign ema_diff  = $signed({1'b0, mech_q}) - $signed({1'b0, smooth_q});
	assign ema_abs   = ema_diff[26] ? 27'(-ema_diff) : 27'(ema_diff);
	assign integ_s   = $signed({{(SUM_W-27){1'b0}}, integ_q});
	assign sum_now   = ffp_q + pp_q + integ_s;
	assign integ_new = integ_s + SUM_W'(mul_prod);
	assign kick      = $signed({{(SUM_W-11-FRAC_BITS){1'b0}}, startup_q, {FRAC_BITS{1'b0}}});
	assign out_free  = !out_valid_q || m_tready;

	// Apply the startup kick while the smoothed speed is below the minimum, then clamp to the throttle range.
	always_comb begin
		fin_a = sum_q;
		if ({10'd0, min_rpm_q} > smooth_q && sum_q < kick)
			fin_a = kick;
		fin_b = fin_a;
		if (fin_b > OUT_HI)
			fin_b = OUT_HI;
		if (fin_b < OUT_LO)
			fin_b = OUT_LO;
	end

	mspf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	mspf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.gain    (mul_g_q),
		.value   (mul_v_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poles_q   <= 8'd14;
			max_rpm_q <= 16'd10000;
			kp_q      <= 16'd6554;
			ki_q      <= 16'd197;
			ff_q      <= 16'd7864;
			min_rpm_q <= 16'd200;
			startup_q <= 11'd200;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_POLES:   poles_q   <= cfg_data[7:0];
				REG_MAX_RPM: max_rpm_q <= cfg_data;
				REG_KP:      kp_q      <= cfg_data;
				REG_KI:      ki_q      <= cfg_data;
				REG_FF:      ff_q      <= cfg_data;
				REG_MIN_RPM: min_rpm_q <= cfg_data;
				REG_STARTUP: startup_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			integ_q     <= '0;
			smooth_q    <= '0;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							REQ_TARGET: begin
								if (in_target < 0)
									held_q <= '0;
								else if (in_target > $signed({1'b0, max_rpm_q}))
									held_q <= max_rpm_q;
								else
									held_q <= in_target[15:0];
							end
							REQ_STOP: begin
								held_q  <= '0;
								integ_q <= '0;
							end
							REQ_TICK: begin
								if (in_period == 16'd0) begin
									mech_q  <= '0;
									state_q <= ST_EMA;
								end else begin
									div_start_q <= 1'b1;
									div_a_q     <= RPM_NUMER;
									div_b_q     <= in_period;
									state_q     <= ST_DIV1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						div_start_q <= 1'b1;
						div_a_q     <= div_quot;
						div_b_q     <= {9'd0, pairs};
						state_q     <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						mech_q  <= div_quot[25:0];
						state_q <= ST_EMA;
					end
				end
				ST_EMA: begin
					if (mech_q == 26'd0) begin
						smooth_q <= '0;
						state_q  <= ST_CHK;
					end else begin
						ema_neg_q   <= ema_diff[26];
						div_start_q <= 1'b1;
						div_a_q     <= {ema_abs, 1'b0};
						div_b_q     <= EMA_DIVISOR;
						state_q     <= ST_DIV3;
					end
				end
				ST_DIV3: begin
					if (div_done) begin
						smooth_q <= ema_neg_q ? smooth_q - div_quot[25:0]
						                      : smooth_q + div_quot[25:0];
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (held_q > min_rpm_q) begin
						err_q       <= $signed({11'd0, held_q}) - $signed({1'b0, smooth_q});
						mul_start_q <= 1'b1;
						mul_g_q     <= ff_q;
						mul_v_q     <= $signed({11'd0, held_q});
						stop_q      <= 1'b0;
						state_q     <= ST_MFF;
					end else begin
						integ_q <= '0;
						stop_q  <= 1'b1;
						thr_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_MFF: begin
					if (mul_done) begin
						ffp_q       <= SUM_W'(mul_prod);
						mul_start_q <= 1'b1;
						mul_g_q     <= kp_q;
						mul_v_q     <= err_q;
						state_q     <= ST_MP;
					end
				end
				ST_MP: begin
					if (mul_done) begin
						pp_q    <= SUM_W'(mul_prod);
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q <= sum_now;
					if (!integ_done_q && sum_now > OUT_LO && sum_now < OUT_HI) begin
						mul_start_q <= 1'b1;
						mul_g_q     <= ki_q;
						mul_v_q     <= err_q;
						state_q     <= ST_MI;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MI: begin
					// Integrate only inside the linear range; clamp to 0..max output.
					if (mul_done) begin
						if (integ_new < 0)
							integ_q <= '0;
						else if (integ_new > OUT_HI)
							integ_q <= OUT_HI[26:0];
						else
							integ_q <= integ_new[26:0];
						state_q <= ST_SUM;
					end
				end
				ST_FIN: begin
					thr_q   <= fin_b[FRAC_BITS+10:FRAC_BITS];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_data_q  <= {3'd0, held_q, smooth_q, thr_q};
						out_user_q  <= stop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// After integration the sum is recomputed in ST_SUM, which then sees the
	// new integrator; hold that pass from integrating twice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_done_q <= 1'b0;
		else if (state_q == ST_MI)
			integ_done_q <= 1'b1;
		else if (state_q == ST_FIN || state_q == ST_IDLE)
			integ_done_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
